### rtl/nlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_pkg
// Shared types and constants for the numeric literal checker.
// ----------------------------------------------------------------------------
package nlc_pkg;

  localparam int unsigned CharW    = 21;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [CharW-1:0] ChMinus = 21'h0002D;
  localparam logic [CharW-1:0] ChPlus  = 21'h0002B;
  localparam logic [CharW-1:0] ChZero  = 21'h00030;
  localparam logic [CharW-1:0] ChNine  = 21'h00039;
  localparam logic [CharW-1:0] ChDot   = 21'h0002E;
  localparam logic [CharW-1:0] ChLowE  = 21'h00065;
  localparam logic [CharW-1:0] ChUpE   = 21'h00045;

  localparam logic [3:0] MaxExpDigitsRst = 4'd4;

  localparam logic [CfgIdxW-1:0] CFG_DECIMAL_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_NEG    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_EXP      = 2'd2;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_INT      = 3'd1,
    PH_FRAC     = 3'd2,
    PH_EXPS     = 3'd3,
    PH_EXPB     = 3'd4,
    PH_EXPS_DOT = 3'd5,
    PH_EXPB_DOT = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MISSING   = 3'd1,
    ERR_NONDIGIT  = 3'd2,
    ERR_LEAD_ZERO = 3'd3,
    ERR_NEG_EXP   = 3'd4,
    ERR_EXP_LONG  = 3'd5,
    ERR_NO_DOT    = 3'd6
  } err_e;

  typedef enum logic [1:0] {
    PART_INT  = 2'd0,
    PART_FRAC = 2'd1,
    PART_EXP  = 2'd2
  } part_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } char_beat_t;

  typedef struct packed {
    logic  literal_ok;
    err_e  error_code;
    part_e error_part;
  } result_t;

  typedef struct packed {
    logic       decimal_mode;
    logic       allow_neg_exp;
    logic [3:0] max_exp_digits;
  } cfg_t;

  // handshake between input stage and the rest
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctrl_t;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] int_digit_count;
    logic       int_has_nondigit;
    logic       int_first_zero;
    logic       frac_digit_seen;
    logic       frac_has_nondigit;
    logic [4:0] exp_digit_count;
    logic       exp_has_nondigit;
    logic       exp_first_zero;
    logic       exp_negative;
  } lit_state_t;

  localparam lit_state_t LitStateRst = '{
    phase: PH_START, int_digit_count: 2'd0, int_has_nondigit: 1'b0,
    int_first_zero: 1'b0, frac_digit_seen: 1'b0, frac_has_nondigit: 1'b0,
    exp_digit_count: 5'd0, exp_has_nondigit: 1'b0, exp_first_zero: 1'b0,
    exp_negative: 1'b0
  };

endpackage
`default_nettype wire

### rtl/nlc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlc channel interfaces
// Valid/ready channels for character beats and verdict beats.
// ----------------------------------------------------------------------------
interface nlc_char_if;
  logic                       valid;
  logic                       ready;
  logic [nlc_pkg::CharW-1:0]  char_code;
  logic                       last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface nlc_res_if;
  logic       valid;
  logic       ready;
  logic       literal_ok;
  logic [2:0] error_code;
  logic [1:0] error_part;

  modport source (output valid, literal_ok, error_code, error_part, input ready);
  modport sink   (input valid, literal_ok, error_code, error_part, output ready);
endinterface
`default_nettype wire

### rtl/nlc_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_in_reg
// Input register stage for character beats.
// ----------------------------------------------------------------------------
module nlc_in_reg (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  nlc_char_if.sink                 char_i,
  input  wire                      out_free_i,
  output nlc_pkg::char_beat_t      beat_o,
  output nlc_pkg::stage_ctrl_t     ctrl_o
);

  logic                valid_q;
  nlc_pkg::char_beat_t beat_q;
  logic                advance;

  // a last char needs a free result slot; other chars always move on
  assign advance      = valid_q && (!beat_q.last_char || out_free_i);
  assign char_i.ready = !valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (char_i.ready) begin
      valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.ready && char_i.valid) begin
      beat_q.char_code <= char_i.char_code;
      beat_q.last_char <= char_i.last_char;
    end
  end

  assign beat_o         = beat_q;
  assign ctrl_o.valid   = valid_q;
  assign ctrl_o.advance = advance;

endmodule
`default_nettype wire

### rtl/nlc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_core
// Literal state update and verdict logic.
// ----------------------------------------------------------------------------
module nlc_core (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  nlc_pkg::char_beat_t   beat_i,
  input  nlc_pkg::stage_ctrl_t  ctrl_i,
  input  nlc_pkg::cfg_t         cfg_i,
  output nlc_pkg::result_t      result_o,
  output nlc_pkg::phase_e       phase_o
);

  nlc_pkg::lit_state_t state_q, state_d, upd;
  logic                [nlc_pkg::CharW-1:0] c;
  logic                is_dig, is_zero, is_minus, is_plus, is_dot, marker;
  logic                skip;
  nlc_pkg::phase_e     p_eff;
  logic                has_exp, dot_seen;

  assign c        = beat_i.char_code;
  assign is_dig   = (c >= nlc_pkg::ChZero) && (c <= nlc_pkg::ChNine);
  assign is_zero  = (c == nlc_pkg::ChZero);
  assign is_minus = (c == nlc_pkg::ChMinus);
  assign is_plus  = (c == nlc_pkg::ChPlus);
  assign is_dot   = (c == nlc_pkg::ChDot);
  assign marker   = (c == nlc_pkg::ChLowE) || (c == nlc_pkg::ChUpE);

  // leading minus on the first char is dropped
  assign skip  = (state_q.phase == nlc_pkg::PH_START) && is_minus;
  assign p_eff = (state_q.phase == nlc_pkg::PH_START) ? nlc_pkg::PH_INT : state_q.phase;

  always_comb begin
    upd = state_q;
    if (state_q.phase == nlc_pkg::PH_START) begin
      upd.phase = nlc_pkg::PH_INT;
    end
    if (!skip) begin
      case (p_eff)
        nlc_pkg::PH_INT: begin
          if (marker) begin
            upd.phase = nlc_pkg::PH_EXPS;
          end else if (is_dot && cfg_i.decimal_mode) begin
            upd.phase = nlc_pkg::PH_FRAC;
          end else if (is_dig) begin
            if (state_q.int_digit_count == 2'd0 && !state_q.int_has_nondigit) begin
              upd.int_first_zero = is_zero;
            end
            if (state_q.int_digit_count != 2'd3) begin
              upd.int_digit_count = state_q.int_digit_count + 2'd1;
            end
          end else begin
            upd.int_has_nondigit = 1'b1;
          end
        end
        nlc_pkg::PH_FRAC: begin
          if (marker) begin
            upd.phase = nlc_pkg::PH_EXPS_DOT;
          end else if (is_dig) begin
            upd.frac_digit_seen = 1'b1;
          end else begin
            upd.frac_has_nondigit = 1'b1;
          end
        end
        nlc_pkg::PH_EXPS, nlc_pkg::PH_EXPS_DOT: begin
          upd.phase = (p_eff == nlc_pkg::PH_EXPS) ? nlc_pkg::PH_EXPB : nlc_pkg::PH_EXPB_DOT;
          if (is_plus || is_minus) begin
            upd.exp_negative = is_minus;
          end else if (is_dig) begin
            if (state_q.exp_digit_count == 5'd0 && !state_q.exp_has_nondigit) begin
              upd.exp_first_zero = is_zero;
            end
            upd.exp_digit_count = state_q.exp_digit_count + 5'd1;
          end else begin
            upd.exp_has_nondigit = 1'b1;
          end
        end
        default: begin
          // exponent body, with or without dot
          if (is_dig) begin
            if (state_q.exp_digit_count == 5'd0 && !state_q.exp_has_nondigit) begin
              upd.exp_first_zero = is_zero;
            end
            if (state_q.exp_digit_count != 5'd31) begin
              upd.exp_digit_count = state_q.exp_digit_count + 5'd1;
            end
          end else begin
            upd.exp_has_nondigit = 1'b1;
          end
        end
      endcase
    end
  end

  // verdict on the updated state
  assign has_exp  = (upd.phase >= nlc_pkg::PH_EXPS);
  assign dot_seen = (upd.phase == nlc_pkg::PH_FRAC) || (upd.phase >= nlc_pkg::PH_EXPS_DOT);

  always_comb begin
    result_o.error_code = nlc_pkg::ERR_NONE;
    result_o.error_part = nlc_pkg::PART_INT;
    if (has_exp && upd.exp_negative && !cfg_i.allow_neg_exp) begin
      result_o.error_code = nlc_pkg::ERR_NEG_EXP;
      result_o.error_part = nlc_pkg::PART_EXP;
    end else if (has_exp && upd.exp_digit_count == 5'd0 && !upd.exp_has_nondigit) begin
      result_o.error_code = nlc_pkg::ERR_MISSING;
      result_o.error_part = nlc_pkg::PART_EXP;
    end else if (has_exp && upd.exp_has_nondigit) begin
      result_o.error_code = nlc_pkg::ERR_NONDIGIT;
      result_o.error_part = nlc_pkg::PART_EXP;
    end else if (has_exp && upd.exp_digit_count > 5'd1 && upd.exp_first_zero) begin
      result_o.error_code = nlc_pkg::ERR_LEAD_ZERO;
      result_o.error_part = nlc_pkg::PART_EXP;
    end else if (has_exp && cfg_i.max_exp_digits != 4'd0 &&
                 upd.exp_digit_count > {1'b0, cfg_i.max_exp_digits}) begin
      result_o.error_code = nlc_pkg::ERR_EXP_LONG;
      result_o.error_part = nlc_pkg::PART_EXP;
    end else if (cfg_i.decimal_mode && !dot_seen) begin
      result_o.error_code = nlc_pkg::ERR_NO_DOT;
    end else if (upd.int_digit_count == 2'd0 && !upd.int_has_nondigit) begin
      result_o.error_code = nlc_pkg::ERR_MISSING;
    end else if (upd.int_has_nondigit) begin
      result_o.error_code = nlc_pkg::ERR_NONDIGIT;
    end else if (upd.int_digit_count > 2'd1 && upd.int_first_zero) begin
      result_o.error_code = nlc_pkg::ERR_LEAD_ZERO;
    end else if (cfg_i.decimal_mode && !upd.frac_digit_seen && !upd.frac_has_nondigit) begin
      result_o.error_code = nlc_pkg::ERR_MISSING;
      result_o.error_part = nlc_pkg::PART_FRAC;
    end else if (cfg_i.decimal_mode && upd.frac_has_nondigit) begin
      result_o.error_code = nlc_pkg::ERR_NONDIGIT;
      result_o.error_part = nlc_pkg::PART_FRAC;
    end
    result_o.literal_ok = (result_o.error_code == nlc_pkg::ERR_NONE);
  end

  always_comb begin
    state_d = state_q;
    if (ctrl_i.valid && ctrl_i.advance) begin
      state_d = beat_i.last_char ? nlc_pkg::LitStateRst : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nlc_pkg::LitStateRst;
    end else begin
      state_q <= state_d;
    end
  end

  assign phase_o = state_q.phase;

endmodule
`default_nettype wire

### rtl/nlc_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nlc_out_reg
// Result register driving the verdict channel.
// ----------------------------------------------------------------------------
module nlc_out_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  nlc_pkg::result_t     result_i,
  nlc_res_if.source            res_o,
  output logic                 free_o
);

  logic             valid_q, valid_d;
  nlc_pkg::result_t result_q;

  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.literal_ok = result_q.literal_ok;
  assign res_o.error_code = result_q.error_code;
  assign res_o.error_part = result_q.error_part;

endmodule
`default_nettype wire

### rtl/numeric_literal_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// numeric_literal_checker
// Checks one numeric literal, one character per beat, and gives a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   char_i carries one code point per beat; last_char marks the final
//   character of a literal. res_o carries one verdict beat per literal
//   (literal_ok, error_code, error_part); other characters give no beat.
//   The cfg port writes the decimal mode, the negative exponent enable and
//   the exponent digit limit; write only between literals.
//   Verdict path: the verdict is computed from the last character held in
//   the input register and loaded into the result register when that
//   character advances; a full result register can delay it.
//   Throughput: one character per cycle, set by the input register and the
//   state update feeding the result register, while no last character waits.
//   Stall: while res_o is held off with a verdict pending, non-final
//   characters keep flowing; the next last character waits in the input
//   register until the result register frees.
//   Reset: literal state returns to start of literal, config registers to
//   their defaults (exponent digit limit 4), both channels empty.
// ----------------------------------------------------------------------------
module numeric_literal_checker (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  nlc_char_if.sink                       char_i,
  nlc_res_if.source                      res_o,
  input  wire                            cfg_we_i,
  input  wire [nlc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire [nlc_pkg::CfgDataW-1:0]    cfg_data_i
);

  nlc_pkg::cfg_t        cfg_q;
  nlc_pkg::char_beat_t  beat;
  nlc_pkg::stage_ctrl_t ctrl;
  nlc_pkg::result_t     result;
  nlc_pkg::phase_e      phase;
  logic                 out_free;
  logic                 load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decimal_mode   <= 1'b0;
      cfg_q.allow_neg_exp  <= 1'b0;
      cfg_q.max_exp_digits <= nlc_pkg::MaxExpDigitsRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nlc_pkg::CFG_DECIMAL_MODE: cfg_q.decimal_mode   <= cfg_data_i[0];
        nlc_pkg::CFG_ALLOW_NEG:    cfg_q.allow_neg_exp  <= cfg_data_i[0];
        nlc_pkg::CFG_MAX_EXP:      cfg_q.max_exp_digits <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  nlc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (char_i),
    .out_free_i (out_free),
    .beat_o     (beat),
    .ctrl_o     (ctrl)
  );

  nlc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .beat_i   (beat),
    .ctrl_i   (ctrl),
    .cfg_i    (cfg_q),
    .result_o (result),
    .phase_o  (phase)
  );

  assign load = ctrl.valid && ctrl.advance && beat.last_char;

  nlc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .result_i (result),
    .res_o    (res_o),
    .free_o   (out_free)
  );

`ifndef SYNTHESIS
  a_res_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(load))
    else $error("verdict beat without a last character");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (phase == nlc_pkg::PH_START))
    else $error("literal state not cleared after verdict");

  a_ok_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.literal_ok == (res_o.error_code == nlc_pkg::ERR_NONE)))
    else $error("literal_ok disagrees with error_code");
`endif

endmodule
`default_nettype wire
